// ===== hw/rtl/lr_pkg.sv =====
`default_nettype none
package lr_pkg;

  localparam int LR_COORD_BITS = 6;
  localparam int LR_GLYPH_BITS = 8;
  localparam int LR_COLOR_BITS = 4;
  localparam int LR_QUEUE_DEPTH = 2;

  // error term and its increments span about four times the canvas side
  function automatic int lr_err_bits(input int coord_bits);
    return coord_bits + 3;
  endfunction

  // width of one classified line record held in the queue
  function automatic int lr_rec_bits(input int coord_bits);
    return 2 + 3 * coord_bits + 3 * lr_err_bits(coord_bits) + LR_COLOR_BITS + LR_GLYPH_BITS;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lr_queue.sv =====
`default_nettype none
module lr_queue
  import lr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = LR_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_wr    = push && !full;
  assign do_rd    = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lr_setup.sv =====
`default_nettype none
module lr_setup
  import lr_pkg::*;
#(
  parameter int COORD_BITS = LR_COORD_BITS,
  localparam int EW = lr_err_bits(COORD_BITS),
  localparam int RW = lr_rec_bits(COORD_BITS)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cmd_valid,
  output logic                          cmd_ready,
  input  wire logic [COORD_BITS-1:0]    ax,
  input  wire logic [COORD_BITS-1:0]    ay,
  input  wire logic [COORD_BITS-1:0]    bx,
  input  wire logic [COORD_BITS-1:0]    by,
  input  wire logic [LR_GLYPH_BITS-1:0] glyph,
  input  wire logic [LR_COLOR_BITS-1:0] color,
  output logic                          rec_push,
  output logic      [RW-1:0]            rec_data,
  input  wire logic                     q_full
);

  logic signed [EW-1:0] dx, dy, adx, ady;
  logic signed [EW-1:0] err0, inc_a, inc_b;
  logic                 xmaj, up, fwd;
  logic [COORD_BITS-1:0] sx, sy, stop;
  logic [RW-1:0]        rec_r, rec_nxt;
  logic                 rec_valid_r, rec_valid_nxt;
  logic                 take;

  always_comb begin
    dx    = signed'(EW'(bx)) - signed'(EW'(ax));
    dy    = signed'(EW'(by)) - signed'(EW'(ay));
    adx   = dx[EW-1] ? -dx : dx;
    ady   = dy[EW-1] ? -dy : dy;
    xmaj  = (ady <= adx);
    up    = (dx[EW-1] && dy[EW-1]) ||
            (!dx[EW-1] && dx != '0 && !dy[EW-1] && dy != '0);
    // step from the endpoint with the smaller major coordinate
    fwd   = xmaj ? !dx[EW-1] : !dy[EW-1];
    sx    = fwd ? ax : bx;
    sy    = fwd ? ay : by;
    if (xmaj) begin
      stop  = fwd ? bx : ax;
      err0  = (ady <<< 1) - adx;
      inc_a = ady <<< 1;
      inc_b = (ady - adx) <<< 1;
    end else begin
      stop  = fwd ? by : ay;
      err0  = (adx <<< 1) - ady;
      inc_a = adx <<< 1;
      inc_b = (adx - ady) <<< 1;
    end
    rec_nxt = {glyph, color, inc_b, inc_a, err0, stop, sy, sx, up, xmaj};
  end

  assign rec_push  = rec_valid_r && !q_full;
  assign cmd_ready = !rec_valid_r || !q_full;
  assign take      = cmd_valid && cmd_ready;
  assign rec_data  = rec_r;

  always_comb begin
    rec_valid_nxt = rec_valid_r;
    if (take) begin
      rec_valid_nxt = 1'b1;
    end else if (rec_push) begin
      rec_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rec_r <= rec_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lr_stepper.sv =====
`default_nettype none
module lr_stepper
  import lr_pkg::*;
#(
  parameter int COORD_BITS = LR_COORD_BITS,
  localparam int EW = lr_err_bits(COORD_BITS),
  localparam int RW = lr_rec_bits(COORD_BITS)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [RW-1:0]            rec_data,
  input  wire logic                     q_empty,
  output logic                          rec_pop,
  output logic                          cell_valid,
  input  wire logic                     cell_ready,
  output logic      [COORD_BITS-1:0]    cell_x,
  output logic      [COORD_BITS-1:0]    cell_y,
  output logic      [LR_GLYPH_BITS-1:0] cell_glyph,
  output logic      [LR_COLOR_BITS-1:0] cell_color,
  output logic                          cell_last
);

  localparam int CB = COORD_BITS;
  localparam int O_X    = 2;
  localparam int O_Y    = O_X + CB;
  localparam int O_STOP = O_Y + CB;
  localparam int O_ERR  = O_STOP + CB;
  localparam int O_INCA = O_ERR + EW;
  localparam int O_INCB = O_INCA + EW;
  localparam int O_COL  = O_INCB + EW;
  localparam int O_GLY  = O_COL + LR_COLOR_BITS;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                state_r, state_nxt;
  logic                  xmaj_r, xmaj_nxt;
  logic                  up_r, up_nxt;
  logic [CB-1:0]         x_r, x_nxt;
  logic [CB-1:0]         y_r, y_nxt;
  logic [CB-1:0]         stop_r, stop_nxt;
  logic signed [EW-1:0]  err_r, err_nxt;
  logic signed [EW-1:0]  inca_r, inca_nxt;
  logic signed [EW-1:0]  incb_r, incb_nxt;
  logic [LR_GLYPH_BITS-1:0] gly_r, gly_nxt;
  logic [LR_COLOR_BITS-1:0] col_r, col_nxt;
  logic                  ov_r, ov_nxt;
  logic [CB-1:0]         ox_r, ox_nxt;
  logic [CB-1:0]         oy_r, oy_nxt;
  logic [LR_GLYPH_BITS-1:0] og_r, og_nxt;
  logic [LR_COLOR_BITS-1:0] oc_r, oc_nxt;
  logic                  ol_r, ol_nxt;
  logic                  slot_free, at_end, move_minor;
  logic [CB-1:0]         minor_step;

  assign slot_free  = !ov_r || cell_ready;
  assign rec_pop    = (state_r == ST_IDLE) && !q_empty;
  assign at_end     = xmaj_r ? (x_r >= stop_r) : (y_r >= stop_r);
  // x-major moves the minor axis on a tie, y-major holds on it
  assign move_minor = xmaj_r ? !err_r[EW-1] : (!err_r[EW-1] && err_r != '0);
  assign minor_step = up_r ? CB'(1) : '1;

  assign cell_valid = ov_r;
  assign cell_x     = ox_r;
  assign cell_y     = oy_r;
  assign cell_glyph = og_r;
  assign cell_color = oc_r;
  assign cell_last  = ol_r;

  always_comb begin
    state_nxt = state_r;
    xmaj_nxt  = xmaj_r;
    up_nxt    = up_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    stop_nxt  = stop_r;
    err_nxt   = err_r;
    inca_nxt  = inca_r;
    incb_nxt  = incb_r;
    gly_nxt   = gly_r;
    col_nxt   = col_r;
    ov_nxt    = ov_r && !cell_ready;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    og_nxt    = og_r;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    unique case (state_r)
      ST_IDLE: begin
        if (rec_pop) begin
          xmaj_nxt  = rec_data[0];
          up_nxt    = rec_data[1];
          x_nxt     = rec_data[O_X +: CB];
          y_nxt     = rec_data[O_Y +: CB];
          stop_nxt  = rec_data[O_STOP +: CB];
          err_nxt   = signed'(rec_data[O_ERR +: EW]);
          inca_nxt  = signed'(rec_data[O_INCA +: EW]);
          incb_nxt  = signed'(rec_data[O_INCB +: EW]);
          col_nxt   = rec_data[O_COL +: LR_COLOR_BITS];
          gly_nxt   = rec_data[O_GLY +: LR_GLYPH_BITS];
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ox_nxt = x_r;
          oy_nxt = y_r;
          og_nxt = gly_r;
          oc_nxt = col_r;
          ol_nxt = at_end;
          if (at_end) begin
            state_nxt = ST_IDLE;
          end else begin
            // advance the major axis, then settle the minor axis and error
            if (xmaj_r) begin
              x_nxt = x_r + 1'b1;
              if (move_minor) begin
                y_nxt = y_r + minor_step;
              end
            end else begin
              y_nxt = y_r + 1'b1;
              if (move_minor) begin
                x_nxt = x_r + minor_step;
              end
            end
            err_nxt = err_r + (move_minor ? incb_r : inca_r);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    xmaj_r <= xmaj_nxt;
    up_r   <= up_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    stop_r <= stop_nxt;
    err_r  <= err_nxt;
    inca_r <= inca_nxt;
    incb_r <= incb_nxt;
    gly_r  <= gly_nxt;
    col_r  <= col_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    og_r   <= og_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/line_rasterizer.sv =====
`default_nettype none
// Channel   Direction  Payload
// in_*      slave      line command: endpoints, glyph, pen colour
// out_*     master     one cell per transaction, tlast on the final cell
//
// A command is classified and registered in the setup stage, then queued; the
// stepper loads it while idle and emits max(|dx|,|dy|)+1 cells at one per cycle
// while out_tready is high, loading the next line only after the last cell.
// Reset (rst_n low, synchronous) empties the queue and drops any line in flight.
// A stall on out_tready holds the stepper; the queue and setup stage keep
// taking commands until they fill.
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int COORD_BITS = LR_COORD_BITS,
  localparam int IN_BITS  = 4 * COORD_BITS + LR_GLYPH_BITS + LR_COLOR_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * COORD_BITS + LR_GLYPH_BITS + LR_COLOR_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // start_x, start_y, end_x, end_y, glyph, pen_color, zero fill
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // cell_x, cell_y, cell_glyph, cell_color, zero fill
  output logic      [OUT_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int CB = COORD_BITS;
  localparam int RW = lr_rec_bits(COORD_BITS);

  logic          rec_push, rec_pop, q_full, q_empty;
  logic [RW-1:0] rec_in, rec_out;
  logic [CB-1:0] cell_x, cell_y;
  logic [LR_GLYPH_BITS-1:0] cell_glyph;
  logic [LR_COLOR_BITS-1:0] cell_color;

  lr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .ax        (in_tdata[0 +: CB]),
    .ay        (in_tdata[CB +: CB]),
    .bx        (in_tdata[2*CB +: CB]),
    .by        (in_tdata[3*CB +: CB]),
    .glyph     (in_tdata[4*CB +: LR_GLYPH_BITS]),
    .color     (in_tdata[4*CB+LR_GLYPH_BITS +: LR_COLOR_BITS]),
    .rec_push  (rec_push),
    .rec_data  (rec_in),
    .q_full    (q_full)
  );

  lr_queue #(.WIDTH(RW), .DEPTH(LR_QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (rec_in),
    .pop       (rec_pop),
    .pop_data  (rec_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  lr_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_data   (rec_out),
    .q_empty    (q_empty),
    .rec_pop    (rec_pop),
    .cell_valid (out_tvalid),
    .cell_ready (out_tready),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_glyph (cell_glyph),
    .cell_color (cell_color),
    .cell_last  (out_tlast)
  );

  assign out_tdata = OUT_W'({cell_color, cell_glyph, cell_y, cell_x});

endmodule
`default_nettype wire
